[src/bilinear_upscale_block_defines.svh]
// Assertion macros shared by the bilinear upscaler modules.
// Depends on nothing; each user must have clk and rst_n in scope.
`ifndef BILINEAR_UPSCALE_BLOCK_DEFINES_SVH
`define BILINEAR_UPSCALE_BLOCK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BUP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bup: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BUP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bup: next-cycle check failed");

`endif

[src/bup_pkg.sv]
// Shared widths, command/status structs and scale helpers for the upscaler.
// Depends on nothing; imported by every module of the block.
package bup_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int POS_W     = 3;
  localparam int SCALE_W   = 4;
  localparam int MAX_SCALE = 8;
  // Column blend (s-i)*p + i*q: at most MAX_SCALE * 255
  localparam int BLEND_W   = 11;
  // Full blend before division: at most MAX_SCALE^2 * 255
  localparam int ACC_W     = 14;
  // Reciprocal of s*s scaled by 2^RECIP_SHIFT, rounded up
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;
  localparam int PROD_W      = ACC_W + RECIP_W;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_SCALE = 3'd0;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;

  // Controller to datapath
  typedef struct packed {
    logic             load;   // capture a new cell
    logic             issue;  // launch one sub-position
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } bup_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic advance;  // pipeline moves this cycle
  } bup_sts_t;

  // Map the raw register to the scale in use: zero acts as one, large values saturate.
  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] raw);
    logic [SCALE_W-1:0] s;
    s = raw;
    if (raw == '0) begin
      s = SCALE_W'(1);
    end else if (raw > SCALE_W'(MAX_SCALE)) begin
      s = SCALE_W'(MAX_SCALE);
    end
    return s;
  endfunction

  // ceil(2^RECIP_SHIFT / (s*s)). Exact floor division for any dividend below 2^ACC_W,
  // since the rounding excess times the dividend stays below 2^RECIP_SHIFT.
  function automatic logic [RECIP_W-1:0] area_recip(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] m;
    case (s)
      4'd1:    m = 21'd1048576;
      4'd2:    m = 21'd262144;
      4'd3:    m = 21'd116509;
      4'd4:    m = 21'd65536;
      4'd5:    m = 21'd41944;
      4'd6:    m = 21'd29128;
      4'd7:    m = 21'd21400;
      4'd8:    m = 21'd16384;
      default: m = 21'd1048576;
    endcase
    return m;
  endfunction

endpackage

[src/bup_cfg.sv]
// APB-style register file holding the scale factor.
// Depends on bup_pkg for widths, addresses and the scale mapping.
module bup_cfg
  import bup_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  output logic [SCALE_W-1:0]   scale_eff
);

  logic [SCALE_W-1:0] scale_r;
  logic [SCALE_W-1:0] scale_nxt;
  logic               wr_en;

  assign pready = 1'b1;

  // Write on the access phase of a transfer to the scale register
  assign wr_en = psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == ADDR_SCALE[PADDR_W-1:2]);

  always_comb begin
    scale_nxt = scale_r;
    if (wr_en) begin
      scale_nxt = pwdata[SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  // Read back the raw register
  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == ADDR_SCALE[PADDR_W-1:2]) begin
      prdata = PDATA_W'(scale_r);
    end
  end

  assign scale_eff = eff_scale(scale_r);

endmodule

[src/bup_ctrl.sv]
// Controller: accepts a cell and walks its sub-positions, column outer, row inner.
// Depends on bup_pkg for the command/status structs and widths.
`include "bilinear_upscale_block_defines.svh"
module bup_ctrl
  import bup_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SCALE_W-1:0] scale_eff,
  input  logic               in_valid,
  output logic               in_ready,
  input  bup_sts_t           sts,
  output bup_cmd_t           cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] pos_max;
  logic             issue;
  logic             last_pos;
  logic             accept;

  assign pos_max  = POS_W'(scale_eff - SCALE_W'(1));
  assign last_pos = (col_r == pos_max) && (row_r == pos_max);
  assign issue    = (state_r == ST_RUN) && sts.advance;

  // Take the next cell when idle or as the last sub-position launches
  assign in_ready = (state_r == ST_IDLE) || (issue && last_pos);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    case (state_r)
      ST_IDLE: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      ST_RUN: begin
        // Advance row, wrap into the next column
        if (issue) begin
          if (last_pos) begin
            state_nxt = ST_IDLE;
            col_nxt   = '0;
            row_nxt   = '0;
          end else if (row_r == pos_max) begin
            row_nxt = '0;
            col_nxt = col_r + POS_W'(1);
          end else begin
            row_nxt = row_r + POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        col_nxt   = '0;
        row_nxt   = '0;
      end
    endcase
    // A new cell always restarts the walk
    if (accept) begin
      state_nxt = ST_RUN;
      col_nxt   = '0;
      row_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  always_comb begin
    cmd.load  = accept;
    cmd.issue = issue;
    cmd.col   = col_r;
    cmd.row   = row_r;
    cmd.last  = last_pos;
  end

  `BUP_ASSERT_SAME(a_pos_in_cell, state_r == ST_RUN, (SCALE_W'(col_r) < scale_eff) && (SCALE_W'(row_r) < scale_eff))
  `BUP_ASSERT_NEXT(a_accept_restarts, accept, (state_r == ST_RUN) && (col_r == '0) && (row_r == '0))
  `BUP_ASSERT_SAME(a_idle_no_issue, state_r == ST_IDLE, !cmd.issue)

endmodule

[src/bup_dp.sv]
// Datapath: holds the cell and runs a three-stage blend, blend and divide pipeline.
// Depends on bup_pkg for widths, structs and the reciprocal table.
`include "bilinear_upscale_block_defines.svh"
module bup_dp
  import bup_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SCALE_W-1:0]  scale_eff,
  input  bup_cmd_t            cmd,
  output bup_sts_t            sts,
  input  logic [SAMPLE_W-1:0] in_top_left,
  input  logic [SAMPLE_W-1:0] in_top_right,
  input  logic [SAMPLE_W-1:0] in_bottom_left,
  input  logic [SAMPLE_W-1:0] in_bottom_right,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_sample_out,
  output logic [POS_W-1:0]    out_col_offset,
  output logic [POS_W-1:0]    out_row_offset,
  output logic                out_last_of_cell
);

  logic [SAMPLE_W-1:0] p00_r, p10_r, p01_r, p11_r;
  logic                advance;

  // Stage 1: blends across columns
  logic [SCALE_W-1:0]  wc;
  logic [BLEND_W-1:0]  blend_top, blend_bot;
  logic                s1_vld_r;
  logic [BLEND_W-1:0]  s1_top_r, s1_bot_r;
  logic [POS_W-1:0]    s1_col_r, s1_row_r;
  logic                s1_last_r;

  // Stage 2: blend across rows
  logic [SCALE_W-1:0]  wr;
  logic [ACC_W-1:0]    acc;
  logic                s2_vld_r;
  logic [ACC_W-1:0]    s2_acc_r;
  logic [POS_W-1:0]    s2_col_r, s2_row_r;
  logic                s2_last_r;

  // Stage 3: divide by s*s through the reciprocal
  logic [PROD_W-1:0]   prod;
  logic                out_vld_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [POS_W-1:0]    out_col_r, out_row_r;
  logic                out_last_r;

  // Whole pipeline moves together unless the result register is blocked
  assign advance     = !out_vld_r || out_ready;
  assign sts.advance = advance;

  // Capture the cell on an input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p00_r <= in_top_left;
      p10_r <= in_top_right;
      p01_r <= in_bottom_left;
      p11_r <= in_bottom_right;
    end
  end

  assign wc        = scale_eff - SCALE_W'(cmd.col);
  assign blend_top = BLEND_W'(wc) * BLEND_W'(p00_r) + BLEND_W'(cmd.col) * BLEND_W'(p10_r);
  assign blend_bot = BLEND_W'(wc) * BLEND_W'(p01_r) + BLEND_W'(cmd.col) * BLEND_W'(p11_r);

  assign wr  = scale_eff - SCALE_W'(s1_row_r);
  assign acc = ACC_W'(wr) * ACC_W'(s1_top_r) + ACC_W'(s1_row_r) * ACC_W'(s1_bot_r);

  assign prod = PROD_W'(s2_acc_r) * PROD_W'(area_recip(scale_eff));

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r  <= cmd.issue;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_top_r     <= blend_top;
      s1_bot_r     <= blend_bot;
      s1_col_r     <= cmd.col;
      s1_row_r     <= cmd.row;
      s1_last_r    <= cmd.last;
      s2_acc_r     <= acc;
      s2_col_r     <= s1_col_r;
      s2_row_r     <= s1_row_r;
      s2_last_r    <= s1_last_r;
      out_sample_r <= prod[RECIP_SHIFT +: SAMPLE_W];
      out_col_r    <= s2_col_r;
      out_row_r    <= s2_row_r;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_sample_out   = out_sample_r;
  assign out_col_offset   = out_col_r;
  assign out_row_offset   = out_row_r;
  assign out_last_of_cell = out_last_r;

  `BUP_ASSERT_SAME(a_last_on_diag, out_vld_r && out_last_r, out_col_r == out_row_r)
  `BUP_ASSERT_NEXT(a_out_holds, out_vld_r && !out_ready, out_vld_r && $stable(out_sample_r) && $stable(out_col_r) && $stable(out_row_r))

endmodule

[src/bilinear_upscale_block.sv]
// Integer-factor bilinear upscaler for one 2x2 cell of one channel.
// An input transfer on the in_ channel delivers top_left, top_right, bottom_left
// and bottom_right. The block answers with s*s interpolated samples on the out_
// channel, column offset outer and row offset inner, last_of_cell set on the
// final one. s is the scale register (byte address 0), with zero read as one and
// values above eight read as eight.
// Throughput: one result per cycle while the receiver is ready; the next cell is
// taken in the cycle its predecessor's last sub-position enters the
// three-stage blend/blend/divide pipeline.
// A stalled receiver freezes the whole pipeline and the sub-position walk; the
// pending result holds until transferred.
// Reset (rst_n low, synchronous) empties the pipeline, returns the controller to
// idle and sets the scale to two.
// Change the scale only while no cell is in flight.
module bilinear_upscale_block
  import bup_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // Input cell
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_top_left,
  input  logic [SAMPLE_W-1:0] in_top_right,
  input  logic [SAMPLE_W-1:0] in_bottom_left,
  input  logic [SAMPLE_W-1:0] in_bottom_right,
  // Results
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_sample_out,
  output logic [POS_W-1:0]    out_col_offset,
  output logic [POS_W-1:0]    out_row_offset,
  output logic                out_last_of_cell
);

  logic [SCALE_W-1:0] scale_eff;
  bup_cmd_t           cmd;
  bup_sts_t           sts;

  bup_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .scale_eff (scale_eff)
  );

  bup_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale_eff (scale_eff),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bup_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .scale_eff        (scale_eff),
    .cmd              (cmd),
    .sts              (sts),
    .in_top_left      (in_top_left),
    .in_top_right     (in_top_right),
    .in_bottom_left   (in_bottom_left),
    .in_bottom_right  (in_bottom_right),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .out_col_offset   (out_col_offset),
    .out_row_offset   (out_row_offset),
    .out_last_of_cell (out_last_of_cell)
  );

endmodule

[tb/sv/bilinear_upscale_checker.sv]
// Scoreboard for the bilinear upscaler: tracks the scale register, predicts each
// cell's interpolated samples and compares every result transfer in order.
// Depends on bup_pkg for widths, the scale register address and its reset value.
`timescale 1ns / 1ps

module bilinear_upscale_checker
  import bup_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic                pready,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_top_left,
  input  logic [SAMPLE_W-1:0] in_top_right,
  input  logic [SAMPLE_W-1:0] in_bottom_left,
  input  logic [SAMPLE_W-1:0] in_bottom_right,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [SAMPLE_W-1:0] out_sample_out,
  input  logic [POS_W-1:0]    out_col_offset,
  input  logic [POS_W-1:0]    out_row_offset,
  input  logic                out_last_of_cell,
  output int                  errors,
  output int                  owed
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic                last;
  } upsample_t;

  upsample_t          owed_samples[$];
  logic [SCALE_W-1:0] scale_reg = SCALE_RESET;
  int                 err_count = 0;

  assign errors = err_count;

  // Print one line per mismatch (capped) and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 40) begin
      $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
    end
    err_count++;
  endtask

  // Zero behaves as one, anything past the maximum saturates.
  function automatic logic [SCALE_W-1:0] scale_in_use(input logic [SCALE_W-1:0] raw);
    logic [SCALE_W-1:0] s;
    s = raw;
    if (raw == '0) begin
      s = SCALE_W'(1);
    end else if (raw > SCALE_W'(MAX_SCALE)) begin
      s = SCALE_W'(MAX_SCALE);
    end
    return s;
  endfunction

  // Expand one 2x2 cell into s*s floored samples, column outer, row inner.
  task automatic predict_cell(input logic [SAMPLE_W-1:0] p00, input logic [SAMPLE_W-1:0] p10,
                              input logic [SAMPLE_W-1:0] p01, input logic [SAMPLE_W-1:0] p11);
    logic [SCALE_W-1:0] s;
    logic [ACC_W-1:0]   area;
    logic [ACC_W-1:0]   acc;
    upsample_t          r;
    s = scale_in_use(scale_reg);
    area = ACC_W'(s) * ACC_W'(s);
    for (int i = 0; i < s; i++) begin
      for (int j = 0; j < s; j++) begin
        acc = ACC_W'((s - i) * (s - j) * p00 + i * (s - j) * p10
                     + (s - i) * j * p01 + i * j * p11);
        r.sample = SAMPLE_W'(acc / area);
        r.col    = POS_W'(i);
        r.row    = POS_W'(j);
        r.last   = (i == s - 1) && (j == s - 1);
        owed_samples.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    upsample_t want;
    if (!rst_n) begin
      owed_samples.delete();
      scale_reg = SCALE_RESET;
      owed <= 0;
    end else begin
      // Track the scale register; other addresses hold nothing
      if (psel && penable && pwrite && pready && paddr == ADDR_SCALE) begin
        scale_reg = pwdata[SCALE_W-1:0];
      end
      if (in_valid && in_ready) begin
        predict_cell(in_top_left, in_top_right, in_bottom_left, in_bottom_right);
      end
      // Compare each result transfer against the oldest owed sample
      if (out_valid && out_ready) begin
        if (owed_samples.size() == 0) begin
          report_mismatch("unowed result, sample", out_sample_out, 0);
        end else begin
          want = owed_samples.pop_front();
          if (out_sample_out !== want.sample) begin
            report_mismatch("sample_out", out_sample_out, want.sample);
          end
          if (out_col_offset !== want.col) begin
            report_mismatch("col_offset", out_col_offset, want.col);
          end
          if (out_row_offset !== want.row) begin
            report_mismatch("row_offset", out_row_offset, want.row);
          end
          if (out_last_of_cell !== want.last) begin
            report_mismatch("last_of_cell", out_last_of_cell, want.last);
          end
        end
      end
      owed <= owed_samples.size();
    end
  end

endmodule

[tb/sv/tb_bilinear_upscale_block.sv]
// Top of the bilinear upscaler testbench: clock, reset, register writes, cell
// stimulus and receiver stalls. Depends on bup_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb_bilinear_upscale_block;
  import bup_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // Address of a register index that does not exist
  localparam logic [PADDR_W-1:0] ADDR_NO_REG = ADDR_SCALE + PADDR_W'(4);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_top_left = '0;
  logic [SAMPLE_W-1:0] in_top_right = '0;
  logic [SAMPLE_W-1:0] in_bottom_left = '0;
  logic [SAMPLE_W-1:0] in_bottom_right = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] out_sample_out;
  logic [POS_W-1:0]    out_col_offset;
  logic [POS_W-1:0]    out_row_offset;
  logic                out_last_of_cell;
  int                  errors;
  int                  owed;
  int                  cycles = 0;
  bit                  gaps_on = 1'b1;
  bit                  stalls_on = 1'b1;

  always #2 clk = ~clk;

  bilinear_upscale_block uut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_top_left, .in_top_right, .in_bottom_left, .in_bottom_right,
    .out_valid, .out_ready, .out_sample_out, .out_col_offset, .out_row_offset,
    .out_last_of_cell
  );

  bilinear_upscale_checker checker_i (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_ready, .in_top_left, .in_top_right, .in_bottom_left, .in_bottom_right,
    .out_valid, .out_ready, .out_sample_out, .out_col_offset, .out_row_offset,
    .out_last_of_cell, .errors, .owed
  );

  // Receiver: stall at random while stalls are enabled
  always @(posedge clk) begin
    out_ready <= !(stalls_on && $urandom_range(99) < 21);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Setup cycle then access cycle; the write lands once pready is seen high.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold off the sender until every owed sample has been transferred.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  // Drain, then load a raw scale value with random junk above the field.
  task automatic set_scale(input logic [SCALE_W-1:0] raw);
    logic [PDATA_W-1:0] data;
    data = $urandom();
    data[SCALE_W-1:0] = raw;
    wait_drained();
    apb_write(ADDR_SCALE, data);
  endtask

  // Offer one cell, with an optional random gap before it, and hold until transfer.
  task automatic send_cell(input logic [SAMPLE_W-1:0] tl, input logic [SAMPLE_W-1:0] tr,
                           input logic [SAMPLE_W-1:0] bl, input logic [SAMPLE_W-1:0] br);
    int gap;
    if (gaps_on && $urandom_range(99) < 21) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_top_left     <= tl;
    in_top_right    <= tr;
    in_bottom_left  <= bl;
    in_bottom_right <= br;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random sample, leaning on the rails now and then.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      default: v = SAMPLE_W'($urandom_range(255));
    endcase
    return v;
  endfunction

  task automatic send_random_cell();
    send_cell(pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endtask

  initial begin
    logic [SCALE_W-1:0] raw;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset scale of two: flat, rails, single corners, alternating bits
    send_cell(8'd0, 8'd0, 8'd0, 8'd0);
    send_cell(8'd255, 8'd255, 8'd255, 8'd255);
    send_cell(8'd255, 8'd0, 8'd0, 8'd0);
    send_cell(8'd0, 8'd255, 8'd0, 8'd0);
    send_cell(8'd0, 8'd0, 8'd255, 8'd0);
    send_cell(8'd0, 8'd0, 8'd0, 8'd255);
    send_cell(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_cell(8'h55, 8'hAA, 8'h55, 8'hAA);

    // Zero scale acts as one
    set_scale(4'd0);
    send_cell(8'd200, 8'd10, 8'd20, 8'd30);
    send_cell(8'd255, 8'd255, 8'd0, 8'd0);

    // Scale of one passes top_left
    set_scale(4'd1);
    send_cell(8'd17, 8'd255, 8'd255, 8'd255);
    send_cell(8'd0, 8'd1, 8'd2, 8'd3);

    // Largest scale
    set_scale(4'd8);
    send_cell(8'd255, 8'd0, 8'd0, 8'd255);
    send_cell(8'd0, 8'd255, 8'd255, 8'd0);

    // Above the maximum saturates; a write to a missing register changes nothing
    set_scale(4'd9);
    send_cell(8'd255, 8'd255, 8'd255, 8'd0);
    wait_drained();
    apb_write(ADDR_NO_REG, 32'h0000_0003);
    send_cell(8'd1, 8'd254, 8'd127, 8'd128);
    set_scale(4'd15);
    send_cell(8'd90, 8'd200, 8'd30, 8'd240);

    // Odd scales whose area is not a power of two
    set_scale(4'd3);
    send_cell(8'd0, 8'd255, 8'd0, 8'd255);
    set_scale(4'd7);
    send_cell(8'd255, 8'd0, 8'd255, 8'd0);
    set_scale(4'd5);
    send_cell(8'd1, 8'd2, 8'd254, 8'd253);

    // Random phases, mostly small scales; phases six to eight run with no idling
    for (int phase = 0; phase < 18; phase++) begin
      if ($urandom_range(3) == 0) begin
        raw = SCALE_W'($urandom_range(15));
      end else begin
        raw = SCALE_W'($urandom_range(1, 4));
      end
      set_scale(raw);
      gaps_on   = !(phase >= 6 && phase <= 8);
      stalls_on = gaps_on;
      repeat (20) send_random_cell();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // Let the last cell drain, then allow the pipeline to settle
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
